### hdl/mbe_pkg.sv
// Shared types, constants and register codes for the escape-time pixel evaluator.
// No dependencies; every other file of the block but mbe_mul imports this package.
`timescale 1ns / 1ps

package mbe_pkg;

  // Palette size; the color band counter wraps at this count.
  localparam int COLORS  = 16;
  localparam int CLR_W   = (COLORS > 2) ? $clog2(COLORS) : 1;

  // Field widths.
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 16;
  localparam int COLOR_W = 5;
  localparam int DATA_W  = 32;
  localparam int CIDX_W  = 3;

  // Register reset values.
  localparam logic signed [31:0] RST_ORIGIN_RE = -32'sd536870912;
  localparam logic signed [31:0] RST_ORIGIN_IM = -32'sd335544320;
  localparam logic [30:0]        RST_STEP      = 31'd655360;
  localparam logic [15:0]        RST_MAX_ITERS = 16'd256;
  localparam logic [15:0]        RST_IPC       = 16'd1;

  // Configuration register codes.
  typedef enum logic [CIDX_W-1:0] {
    REG_ORIGIN_RE = 3'd0,
    REG_ORIGIN_IM = 3'd1,
    REG_STEP_RE   = 3'd2,
    REG_STEP_IM   = 3'd3,
    REG_START_RE  = 3'd4,
    REG_START_IM  = 3'd5,
    REG_MAX_ITERS = 3'd6,
    REG_IPC       = 3'd7
  } reg_idx_t;

  // Register file contents as seen by the iteration engine.
  typedef struct packed {
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [30:0]        step_re;
    logic [30:0]        step_im;
    logic signed [31:0] start_re;
    logic signed [31:0] start_im;
    logic [15:0]        max_iters;
    logic [15:0]        iters_per_color;
  } cfg_t;

  // One finished result item.
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [CNT_W-1:0]   iterations;
    logic               escaped;
  } res_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CRE,
    S_CIM,
    S_LDC,
    S_XX,
    S_YY,
    S_XY,
    S_UPD,
    S_FIN
  } state_t;

endpackage

### hdl/mbe_cfg.sv
// Configuration register file for the escape-time pixel evaluator.
// Depends on mbe_pkg for the register codes, reset values and cfg_t.
`timescale 1ns / 1ps

module mbe_cfg
  import mbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata,
  output cfg_t              cfg
);

  cfg_t regs_r;

  // Each write lands in one register, masked to that register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.origin_re       <= RST_ORIGIN_RE;
      regs_r.origin_im       <= RST_ORIGIN_IM;
      regs_r.step_re         <= RST_STEP;
      regs_r.step_im         <= RST_STEP;
      regs_r.start_re        <= '0;
      regs_r.start_im        <= '0;
      regs_r.max_iters       <= RST_MAX_ITERS;
      regs_r.iters_per_color <= RST_IPC;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ORIGIN_RE: regs_r.origin_re       <= $signed(cfg_wdata);
        REG_ORIGIN_IM: regs_r.origin_im       <= $signed(cfg_wdata);
        REG_STEP_RE:   regs_r.step_re         <= cfg_wdata[30:0];
        REG_STEP_IM:   regs_r.step_im         <= cfg_wdata[30:0];
        REG_START_RE:  regs_r.start_re        <= $signed(cfg_wdata);
        REG_START_IM:  regs_r.start_im        <= $signed(cfg_wdata);
        REG_MAX_ITERS: regs_r.max_iters       <= cfg_wdata[15:0];
        REG_IPC:       regs_r.iters_per_color <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs_r;

endmodule

### hdl/mbe_mul.sv
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
// Standalone; used by mbe_iter for coordinates and all iteration products.
`timescale 1ns / 1ps

module mbe_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod_r
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

### hdl/mbe_iter.sv
// Sequencer and datapath that run z = z^2 + c on the shared multiplier.
// Depends on mbe_pkg and instantiates mbe_mul.
`timescale 1ns / 1ps

module mbe_iter
  import mbe_pkg::*;
#(
  parameter int NUM_COLORS = COLORS
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] in_column,
  input  logic [IDX_W-1:0] in_row,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  localparam int                 PAL_W   = (NUM_COLORS > 2) ? $clog2(NUM_COLORS) : 1;
  localparam logic signed [43:0] SAT_MAX = 44'sh0007FFFFFFF;
  localparam logic signed [43:0] SAT_MIN = 44'shFFF80000000;
  localparam logic [63:0]        FOUR    = 64'h0400_0000_0000_0000;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]   col_r, row_r;
  logic signed [31:0] cre_r, cim_r, x_r, y_r;
  logic [63:0]        xx_r, yy_r;
  logic [CNT_W-1:0]   iter_r, band_cnt_r;
  logic [PAL_W-1:0]   color_cnt_r;
  logic               esc_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_r;

  logic signed [43:0] cre_sum, cim_sum, nx_sum, ny_sum;
  logic [63:0]        mag;
  logic               escape, budget_out;
  logic [CNT_W-1:0]   band_m1;
  logic [8:0]         color_sum;

  // Clamp a wide signed sum to the Q4.28 range.
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      return 32'sh80000000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

  mbe_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // Coordinate sums, escape test and the next z from the registered products.
  assign cre_sum    = 44'(cfg.origin_re) + $signed(prod_r[43:0]);
  assign cim_sum    = 44'(cfg.origin_im) + $signed(prod_r[43:0]);
  assign mag        = xx_r + $unsigned(prod_r);
  assign escape     = mag > FOUR;
  assign budget_out = iter_r == cfg.max_iters;
  assign nx_sum     = 44'($signed(xx_r[63:28])) - 44'($signed(yy_r[63:28])) + 44'(cre_r);
  assign ny_sum     = 44'($signed(prod_r[63:27])) + 44'(cim_r);

  // A band width of zero behaves as one.
  assign band_m1 = (cfg.iters_per_color == '0) ? '0 : cfg.iters_per_color - 16'd1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CRE;
      S_CRE:  state_nxt = S_CIM;
      S_CIM:  state_nxt = S_LDC;
      S_LDC:  state_nxt = S_XX;
      S_XX:   state_nxt = budget_out ? S_FIN : S_YY;
      S_YY:   state_nxt = S_XY;
      S_XY:   state_nxt = escape ? S_FIN : S_UPD;
      S_UPD:  state_nxt = S_XX;
      S_FIN:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake and multiplier operand selection.
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_CRE: begin
        mul_a = $signed(32'(col_r));
        mul_b = $signed(32'(cfg.step_re));
      end
      S_CIM: begin
        mul_a = $signed(32'(row_r));
        mul_b = $signed(32'(cfg.step_im));
      end
      S_XX: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      S_YY: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      S_XY: begin
        mul_a = x_r;
        mul_b = y_r;
      end
      S_FIN: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers, loaded as the sequence advances.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          col_r       <= in_column;
          row_r       <= in_row;
          x_r         <= cfg.start_re;
          y_r         <= cfg.start_im;
          iter_r      <= '0;
          band_cnt_r  <= '0;
          color_cnt_r <= '0;
          esc_r       <= 1'b0;
        end
      end
      S_CIM: cre_r <= sat32(cre_sum);
      S_LDC: cim_r <= sat32(cim_sum);
      S_YY:  xx_r  <= prod_r;
      S_XY: begin
        yy_r  <= prod_r;
        esc_r <= escape;
      end
      S_UPD: begin
        x_r    <= sat32(nx_sum);
        y_r    <= sat32(ny_sum);
        iter_r <= iter_r + 16'd1;
        // Count finished bands modulo the palette size.
        if (band_cnt_r == band_m1) begin
          band_cnt_r <= '0;
          if (color_cnt_r == PAL_W'(NUM_COLORS - 1)) begin
            color_cnt_r <= '0;
          end else begin
            color_cnt_r <= color_cnt_r + 1'b1;
          end
        end else begin
          band_cnt_r <= band_cnt_r + 16'd1;
        end
      end
      default: ;
    endcase
  end

  // Result item.
  assign color_sum      = 9'(color_cnt_r) + 9'd1;
  assign res.color      = esc_r ? color_sum[COLOR_W-1:0] : '0;
  assign res.iterations = iter_r;
  assign res.escaped    = esc_r;

`ifndef SYNTHESIS
  a_iter_in_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (iter_r <= cfg.max_iters))
    else $error("iteration count passed the budget");

  a_upd_after_test: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> ($past(state_r) == S_XY))
    else $error("z update without a preceding bailout test");

  a_no_escape_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.escaped) |-> (res.color == '0 && res.iterations == cfg.max_iters))
    else $error("non-escaped item has wrong color or count");
`endif

endmodule

### hdl/mandelbrot_escape_time.sv
// Top level of the escape-time pixel evaluator: register file, engine, output stage.
// Depends on mbe_pkg, mbe_cfg and mbe_iter.
//
//   Channel  Ports                               Direction  Handshake
//   in       in_column, in_row                   input      in_valid / in_ready
//   out      out_color, out_iterations,          output     out_valid / out_ready
//            out_escaped
//   cfg      cfg_index, cfg_wdata                input      cfg_we, no wait
//
// An item runs at most max_iters iterations. The single 32 x 32 multiplier is used
// for x*x, y*y and x*y in turn, so each iteration steps through S_XX, S_YY, S_XY
// and S_UPD, after the setup states S_CRE, S_CIM and S_LDC for the two coordinates.
// Reset is synchronous and active low and restores the register defaults.
// A finished item sits in the output register; the next item is accepted meanwhile,
// and the engine only stalls at its end if that register is still occupied.
`timescale 1ns / 1ps

module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int NUM_COLORS = COLORS
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IDX_W-1:0]   in_column,
  input  logic [IDX_W-1:0]   in_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COLOR_W-1:0] out_color,
  output logic [CNT_W-1:0]   out_iterations,
  output logic               out_escaped,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0]  cfg_wdata
);

  cfg_t cfg;
  res_t res;
  res_t out_r;
  logic res_valid, res_ready;
  logic out_valid_r;

  mbe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mbe_iter #(
    .NUM_COLORS (NUM_COLORS)
  ) u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_column (in_column),
    .in_row    (in_row),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: takes a result when empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_color      = out_r.color;
  assign out_iterations = out_r.iterations;
  assign out_escaped    = out_r.escaped;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("engine ready again right after taking an item");
`endif

endmodule
